### sv/ertt_pkg.sv
package ertt_pkg;

   localparam int MaxEntriesDef = 64;
   localparam int FracBitsDef   = 16;
   localparam int WinW          = 29;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_CANCEL = 2'd1,
      OP_TICK   = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_APPEND,
      ST_OUT,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_DIV,
      ST_MUL1,
      ST_MUL2,
      ST_BLEND,
      ST_EMIT
   } state_type;

endpackage

### sv/eased_rect_tween_table.sv
// Start and cancel scan the table with one read and one compare per entry, and a start
// then appends; a query answer is registered after the same scan.
// Tick: each animating entry takes a FRAC_BITS-step divide, two multiplies and four
// blends on one shared multiplier; finished entries are dropped, and output stalls
// can hold the walk before any result. One transaction in flight.
// Synchronous reset empties the table; the entry memory is not cleared.
module eased_rect_tween_table #(
   parameter int MAX_ENTRIES = ertt_pkg::MaxEntriesDef,
   parameter int FRAC_BITS   = ertt_pkg::FracBitsDef
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // window_id[28:0], from_x, from_y, from_w, from_h, to_x, to_y, to_w, to_h,
   // length_ms, now_ms, zero pad to 208 bits
   input  logic [207:0] req_tdata,
   // op
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_window[28:0], pos_x, pos_y, size_w, size_h, finished, is_animating,
   // zero pad to 96 bits
   output logic [95:0]  rsp_tdata,
   // kind
   output logic         rsp_tuser,
   output logic         rsp_tlast
);
   localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int WW  = ertt_pkg::WinW;
   localparam int EW  = WW + 64 + 64 + 32 + 16;
   localparam int QW  = FRAC_BITS + 1;
   localparam int MW  = (QW + 1 > 18) ? QW + 1 : 18;
   localparam int SW  = FRAC_BITS + 20;
   localparam int DCW = $clog2(FRAC_BITS + 1);
   localparam logic [QW-1:0] OneFx = QW'(1) << FRAC_BITS;

   // Entry memory: window, from, to, start, length
   logic [EW-1:0] mem [MAX_ENTRIES];
   logic [EW-1:0] rd_q;
   logic [IW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q <= mem[rd_addr];
   end

   ertt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in, i_ff, i_in, k_ff, k_in;
   ertt_pkg::op_type  op_ff;
   logic [WW-1:0]     win_ff;
   logic [63:0]       from_ff, to_ff;
   logic [15:0]       len_ff;
   logic [31:0]       now_ff;
   logic              found_ff, found_in;
   logic [EW-1:0]     ent_ff, ent_in;

   // divider, cubic and blend
   logic [15:0]       rem_ff, rem_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [DCW-1:0]    dcnt_ff, dcnt_in;
   logic [QW-1:0]     u_ff, u_in, u2_ff, u2_in, e_ff, e_in;
   logic [1:0]        c_ff, c_in;
   logic [63:0]       res_ff, res_in;
   logic              fin_ff, fin_in;

   // output register
   logic              ov_ff, ov_in;
   logic [95:0]       od_ff, od_in;
   logic              ou_ff, ou_in, ol_ff, ol_in;

   logic              out_free;
   logic              req_fire;
   ertt_pkg::op_type  req_op;
   logic [WW-1:0]     req_win;

   assign out_free   = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == ertt_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = ertt_pkg::op_type'(req_tuser);
   assign req_win    = req_tdata[WW-1:0];
   assign rd_addr    = i_ff[IW-1:0];

   logic [WW-1:0] ent_win, rd_win;
   logic [63:0]   ent_from, ent_to, rd_to;
   logic [15:0]   ent_len, rd_len;
   logic [31:0]   rd_start, rd_elapsed;
   logic          rd_done;
   assign ent_win    = ent_ff[EW-1 -: WW];
   assign ent_from   = ent_ff[175:112];
   assign ent_to     = ent_ff[111:48];
   assign ent_len    = ent_ff[15:0];
   assign rd_win     = rd_q[EW-1 -: WW];
   assign rd_to      = rd_q[111:48];
   assign rd_start   = rd_q[47:16];
   assign rd_len     = rd_q[15:0];
   assign rd_elapsed = now_ff - rd_start;
   assign rd_done    = rd_elapsed >= {16'h0, rd_len};

   // restoring divide of elapsed * 2^FRAC_BITS by length; elapsed < length here
   logic [16:0] rshift, rdiff;
   logic        ge;
   assign rshift = {rem_ff, 1'b0};
   assign rdiff  = rshift - {1'b0, ent_len};
   assign ge     = rshift >= {1'b0, ent_len};

   // shared multiplier
   logic signed [MW-1:0]   ma, mb;
   logic signed [2*MW-1:0] mp;
   assign mp = ma * mb;

   logic [15:0]        fpart, tpart;
   logic signed [17:0] a_s, b_s, diff;
   assign fpart = ent_from[16*c_ff +: 16];
   assign tpart = ent_to[16*c_ff +: 16];
   always_comb begin
      if (!c_ff[1]) begin
         a_s = {{2{fpart[15]}}, fpart};
         b_s = {{2{tpart[15]}}, tpart};
      end else begin
         a_s = {2'b00, fpart};
         b_s = {2'b00, tpart};
      end
      diff = b_s - a_s;
   end

   // start * 2^F + delta * e, shifted down with truncation toward zero
   logic signed [SW-1:0] bsum;
   logic [SW-1:0]        babs, bshift;
   logic [15:0]          bmag, bres;
   always_comb begin
      bsum   = (SW'(a_s) <<< FRAC_BITS) + SW'(mp);
      babs   = bsum[SW-1] ? SW'(-bsum) : SW'(bsum);
      bshift = babs >> FRAC_BITS;
      bmag   = bshift[15:0];
      bres   = bsum[SW-1] ? 16'(-bmag) : bmag;
   end

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (state_ff)
         ertt_pkg::ST_MUL1: begin
            ma = MW'(u_ff);
            mb = MW'(u_ff);
         end
         ertt_pkg::ST_MUL2: begin
            ma = MW'(u2_ff);
            mb = MW'(u_ff);
         end
         ertt_pkg::ST_BLEND: begin
            ma = MW'(diff);
            mb = MW'(e_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ertt_pkg::ST_IDLE:
            if (req_fire) begin
               if (req_op == ertt_pkg::OP_TICK)
                  state_in = ertt_pkg::ST_TICK_RD;
               else if (!(req_op == ertt_pkg::OP_START && req_win == '0))
                  state_in = ertt_pkg::ST_SCAN_RD;
            end
         ertt_pkg::ST_SCAN_RD:
            if (i_ff < count_ff) state_in = ertt_pkg::ST_SCAN;
            else if (op_ff == ertt_pkg::OP_START) state_in = ertt_pkg::ST_APPEND;
            else if (op_ff == ertt_pkg::OP_QUERY) state_in = ertt_pkg::ST_OUT;
            else state_in = ertt_pkg::ST_IDLE;
         ertt_pkg::ST_SCAN:   state_in = ertt_pkg::ST_SCAN_RD;
         ertt_pkg::ST_APPEND: state_in = ertt_pkg::ST_IDLE;
         ertt_pkg::ST_OUT:    if (out_free) state_in = ertt_pkg::ST_IDLE;
         ertt_pkg::ST_TICK_RD:
            state_in = (i_ff < count_ff) ? ertt_pkg::ST_TICK_CHK : ertt_pkg::ST_IDLE;
         ertt_pkg::ST_TICK_CHK:
            state_in = rd_done ? ertt_pkg::ST_EMIT : ertt_pkg::ST_DIV;
         ertt_pkg::ST_DIV:
            if (dcnt_ff == DCW'(1)) state_in = ertt_pkg::ST_MUL1;
         ertt_pkg::ST_MUL1:  state_in = ertt_pkg::ST_MUL2;
         ertt_pkg::ST_MUL2:  state_in = ertt_pkg::ST_BLEND;
         ertt_pkg::ST_BLEND: if (c_ff == 2'd3) state_in = ertt_pkg::ST_EMIT;
         ertt_pkg::ST_EMIT:  if (out_free) state_in = ertt_pkg::ST_TICK_RD;
         default: state_in = ertt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff; i_in = i_ff; k_in = k_ff; found_in = found_ff;
      ent_in = ent_ff;
      rem_in = rem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff;
      u_in = u_ff; u2_in = u2_ff; e_in = e_ff; c_in = c_ff;
      res_in = res_ff; fin_in = fin_ff;
      ov_in = ov_ff && !rsp_tready; od_in = od_ff; ou_in = ou_ff; ol_in = ol_ff;
      wr_en = 1'b0; wr_addr = k_ff[IW-1:0]; wr_data = rd_q;
      unique case (state_ff)
         ertt_pkg::ST_IDLE:
            if (req_fire) begin
               i_in = '0; k_in = '0; found_in = 1'b0;
            end
         ertt_pkg::ST_SCAN_RD:
            if (i_ff >= count_ff && op_ff != ertt_pkg::OP_QUERY) count_in = k_ff;
         ertt_pkg::ST_SCAN: begin
            // kept entries slide down over removed ones
            if (rd_win == win_ff) found_in = 1'b1;
            else if (op_ff != ertt_pkg::OP_QUERY) begin
               wr_en = 1'b1; k_in = k_ff + CW'(1);
            end
            i_in = i_ff + CW'(1);
         end
         ertt_pkg::ST_APPEND:
            if (count_ff < CW'(MAX_ENTRIES)) begin
               wr_en = 1'b1; wr_addr = count_ff[IW-1:0];
               wr_data = {win_ff, from_ff, to_ff, now_ff, len_ff};
               count_in = count_ff + CW'(1);
            end
         ertt_pkg::ST_OUT:
            if (out_free) begin
               ov_in = 1'b1; ou_in = 1'b1; ol_in = 1'b1;
               od_in = '0; od_in[WW-1:0] = win_ff; od_in[94] = found_ff;
            end
         ertt_pkg::ST_TICK_RD:
            if (i_ff >= count_ff) count_in = k_ff;
         ertt_pkg::ST_TICK_CHK: begin
            ent_in = rd_q; fin_in = rd_done; res_in = rd_to;
            rem_in = rd_elapsed[15:0]; quo_in = '0;
            dcnt_in = DCW'(FRAC_BITS); c_in = '0;
         end
         ertt_pkg::ST_DIV: begin
            rem_in  = ge ? rdiff[15:0] : rshift[15:0];
            quo_in  = {quo_ff[FRAC_BITS-2:0], ge};
            dcnt_in = dcnt_ff - DCW'(1);
            u_in    = OneFx - QW'(quo_in);
         end
         ertt_pkg::ST_MUL1: u2_in = mp[FRAC_BITS +: QW];
         ertt_pkg::ST_MUL2: e_in = OneFx - mp[FRAC_BITS +: QW];
         ertt_pkg::ST_BLEND: begin
            res_in[16*c_ff +: 16] = bres; c_in = c_ff + 2'd1;
         end
         ertt_pkg::ST_EMIT:
            if (out_free) begin
               // count only moves at the end of the walk, so it marks the final result
               ov_in = 1'b1; ou_in = 1'b0; ol_in = (i_ff == count_ff - CW'(1));
               od_in = '0; od_in[WW-1:0] = ent_win; od_in[WW +: 64] = res_ff;
               od_in[WW+64] = fin_ff;
               if (!fin_ff) begin
                  wr_en = 1'b1; wr_data = ent_ff; k_in = k_ff + CW'(1);
               end
               i_in = i_ff + CW'(1);
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ertt_pkg::ST_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; k_ff <= k_in; found_ff <= found_in; ent_ff <= ent_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dcnt_ff <= dcnt_in;
      u_ff <= u_in; u2_ff <= u2_in; e_ff <= e_in; c_ff <= c_in;
      res_ff <= res_in; fin_ff <= fin_in;
      od_ff <= od_in; ou_ff <= ou_in; ol_ff <= ol_in;
      if (req_fire) begin
         op_ff   <= req_op;
         win_ff  <= req_win;
         from_ff <= req_tdata[92:29];
         to_ff   <= req_tdata[156:93];
         len_ff  <= req_tdata[172:157];
         now_ff  <= req_tdata[204:173];
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ou_ff;
   assign rsp_tlast  = ol_ff;

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES)) else $error("count overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped while stalled");
   a_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast) else $error("query not last");
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int  NUM_SLOTS   = 64;
   localparam int  FRAC        = 16;
   localparam longint UNITY    = 64'd1 << FRAC;
   localparam int  DRAIN_WAIT  = 200;
   localparam longint CYCLE_LIMIT = 6_000_000;

   typedef struct {
      ertt_pkg::op_type   op;
      logic [28:0]        win;
      logic [15:0]        rect_from [4];
      logic [15:0]        rect_to [4];
      logic [15:0]        len;
      logic [31:0]        now;
   } tween_req_type;

   typedef struct packed {
      logic        kind;
      logic [28:0] win;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] size_w;
      logic [15:0] size_h;
      logic        finished;
      logic        animating;
      logic        last;
   } move_rsp_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [207:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   eased_rect_tween_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // shadow copy of the animation table
   logic [28:0] anim_win [NUM_SLOTS];
   logic [15:0] anim_from [NUM_SLOTS][4];
   logic [15:0] anim_to [NUM_SLOTS][4];
   logic [31:0] anim_start [NUM_SLOTS];
   logic [15:0] anim_len [NUM_SLOTS];
   int          anim_count;

   move_rsp_type pending_moves[$];
   int          mismatches = 0;
   longint      cycle_cnt = 0;
   bit          idle_enable;
   int          rsp_stall = 0;
   logic [28:0] win_pool [12];
   logic [31:0] clock_ms;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("eased_rect_tween_table test failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (idle_enable && rsp_stall == 0 && $urandom_range(0, 4) == 0)
         rsp_stall = $urandom_range(1, 7);
      rsp_tready <= (rsp_stall == 0);
      if (rsp_stall > 0)
         rsp_stall--;
   end

   function automatic void drop_window(logic [28:0] win);
      int k;
      k = 0;
      for (int i = 0; i < anim_count; i++) begin
         if (anim_win[i] != win) begin
            anim_win[k]   = anim_win[i];
            anim_from[k]  = anim_from[i];
            anim_to[k]    = anim_to[i];
            anim_start[k] = anim_start[i];
            anim_len[k]   = anim_len[i];
            k++;
         end
      end
      anim_count = k;
   endfunction

   // start + (target - start) * e, truncated toward zero
   function automatic logic [15:0] ease_coord(logic [15:0] s, logic [15:0] d, bit sgn,
                                              longint e);
      longint a, b, sum, r;
      a   = sgn ? longint'($signed(s)) : longint'({48'd0, s});
      b   = sgn ? longint'($signed(d)) : longint'({48'd0, d});
      sum = a * UNITY + (b - a) * e;
      r   = (sum < 0) ? -((-sum) >>> FRAC) : (sum >>> FRAC);
      return r[15:0];
   endfunction

   function automatic void predict_tween(tween_req_type it);
      move_rsp_type r;
      int        k, n;
      logic [31:0] elapsed;
      longint    t, u, u2, u3, e;
      r = '0;
      case (it.op)
         ertt_pkg::OP_START: begin
            if (it.win != 0) begin
               drop_window(it.win);
               if (anim_count < NUM_SLOTS) begin
                  anim_win[anim_count]   = it.win;
                  anim_from[anim_count]  = it.rect_from;
                  anim_to[anim_count]    = it.rect_to;
                  anim_start[anim_count] = it.now;
                  anim_len[anim_count]   = it.len;
                  anim_count++;
               end
            end
         end
         ertt_pkg::OP_CANCEL: drop_window(it.win);
         ertt_pkg::OP_QUERY: begin
            r.kind = 1'b1;
            r.win  = it.win;
            r.last = 1'b1;
            for (int i = 0; i < anim_count; i++)
               if (anim_win[i] == it.win)
                  r.animating = 1'b1;
            pending_moves.push_back(r);
         end
         default: begin
            k = 0;
            n = anim_count;
            for (int i = 0; i < n; i++) begin
               r = '0;
               r.win   = anim_win[i];
               r.last  = (i == n - 1);
               elapsed = it.now - anim_start[i];
               if (elapsed >= {16'd0, anim_len[i]}) begin
                  r.pos_x    = anim_to[i][0];
                  r.pos_y    = anim_to[i][1];
                  r.size_w   = anim_to[i][2];
                  r.size_h   = anim_to[i][3];
                  r.finished = 1'b1;
               end else begin
                  t  = (longint'(elapsed) << FRAC) / longint'(anim_len[i]);
                  u  = UNITY - t;
                  u2 = (u * u) >> FRAC;
                  u3 = (u2 * u) >> FRAC;
                  e  = UNITY - u3;
                  r.pos_x  = ease_coord(anim_from[i][0], anim_to[i][0], 1'b1, e);
                  r.pos_y  = ease_coord(anim_from[i][1], anim_to[i][1], 1'b1, e);
                  r.size_w = ease_coord(anim_from[i][2], anim_to[i][2], 1'b0, e);
                  r.size_h = ease_coord(anim_from[i][3], anim_to[i][3], 1'b0, e);
                  anim_win[k]   = anim_win[i];
                  anim_from[k]  = anim_from[i];
                  anim_to[k]    = anim_to[i];
                  anim_start[k] = anim_start[i];
                  anim_len[k]   = anim_len[i];
                  k++;
               end
               pending_moves.push_back(r);
            end
            anim_count = k;
         end
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      move_rsp_type want;
      move_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind      = rsp_tuser;
         got.win       = rsp_tdata[28:0];
         got.pos_x     = rsp_tdata[44:29];
         got.pos_y     = rsp_tdata[60:45];
         got.size_w    = rsp_tdata[76:61];
         got.size_h    = rsp_tdata[92:77];
         got.finished  = rsp_tdata[93];
         got.animating = rsp_tdata[94];
         got.last      = rsp_tlast;
         if (pending_moves.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: win %0h kind %0b", got.win, got.kind);
         end else begin
            want = pending_moves.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp kind %0b win %0h x %0d y %0d w %0d h %0d",
                     want.kind, want.win, $signed(want.pos_x), $signed(want.pos_y),
                     want.size_w, want.size_h);
                  $display("          exp fin %0b anim %0b last %0b",
                     want.finished, want.animating, want.last);
                  $display("          got kind %0b win %0h x %0d y %0d w %0d h %0d",
                     got.kind, got.win, $signed(got.pos_x), $signed(got.pos_y),
                     got.size_w, got.size_h);
                  $display("          got fin %0b anim %0b last %0b",
                     got.finished, got.animating, got.last);
               end
            end
         end
      end
   end

   task automatic send_item(tween_req_type it);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {3'd0, it.now, it.len, it.rect_to[3], it.rect_to[2], it.rect_to[1],
                     it.rect_to[0], it.rect_from[3], it.rect_from[2], it.rect_from[1],
                     it.rect_from[0], it.win};
      do @(posedge clock); while (!req_tready);
      predict_tween(it);
   endtask

   function automatic tween_req_type random_item(ertt_pkg::op_type op, logic [28:0] win);
      tween_req_type it;
      it.op  = op;
      it.win = win;
      for (int c = 0; c < 4; c++) begin
         it.rect_from[c] = 16'($urandom);
         it.rect_to[c]   = 16'($urandom);
      end
      it.len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
      it.now = clock_ms;
      return it;
   endfunction

   task automatic go_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_moves.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic test_directed();
      tween_req_type it;
      it = random_item(ertt_pkg::OP_QUERY, 29'd5);
      send_item(it);
      it = random_item(ertt_pkg::OP_TICK, 29'd0);
      send_item(it);
      it = random_item(ertt_pkg::OP_START, 29'd0);      // ignored
      send_item(it);
      it = random_item(ertt_pkg::OP_START, 29'd1);
      it.rect_from = '{16'h8000, 16'h8000, 16'h0000, 16'h0000};
      it.rect_to   = '{16'h7fff, 16'h7fff, 16'hffff, 16'hffff};
      it.len = 16'd1000;
      it.now = 32'd0;
      send_item(it);
      it = random_item(ertt_pkg::OP_START, 29'h1fffffff);
      it.rect_from = '{16'h7fff, 16'h7fff, 16'hffff, 16'hffff};
      it.rect_to   = '{16'h8000, 16'h8000, 16'h0000, 16'h0000};
      it.len = 16'hffff;
      it.now = 32'hffffff00;
      send_item(it);
      it = random_item(ertt_pkg::OP_START, 29'd3);      // zero length
      it.len = 16'd0;
      it.now = 32'd10;
      send_item(it);
      it = random_item(ertt_pkg::OP_QUERY, 29'd1);
      send_item(it);
      it = random_item(ertt_pkg::OP_TICK, 29'd0);
      it.now = 32'd500;
      send_item(it);
      it = random_item(ertt_pkg::OP_TICK, 29'd0);
      it.now = 32'd999;
      send_item(it);
      it = random_item(ertt_pkg::OP_START, 29'd1);      // restart replaces old entry
      it.now = 32'd2000;
      it.len = 16'd300;
      send_item(it);
      it = random_item(ertt_pkg::OP_QUERY, 29'h1fffffff);
      send_item(it);
      it = random_item(ertt_pkg::OP_TICK, 29'd0);       // clock stepping backwards
      it.now = 32'd1500;
      send_item(it);
      it = random_item(ertt_pkg::OP_START, 29'd7);
      it.now = 32'd100;
      it.len = 16'd50;
      send_item(it);
      it = random_item(ertt_pkg::OP_CANCEL, 29'd7);
      send_item(it);
      it = random_item(ertt_pkg::OP_CANCEL, 29'd99);
      send_item(it);
      it = random_item(ertt_pkg::OP_QUERY, 29'd7);
      send_item(it);
      it = random_item(ertt_pkg::OP_TICK, 29'd0);
      it.now = 32'hffffffff;
      send_item(it);
      go_quiet();
   endtask

   task automatic test_table_full();
      tween_req_type it;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         it = random_item(ertt_pkg::OP_START, 29'(100 + i));
         it.now = 32'd0;
         it.len = 16'(i * 7);
         send_item(it);
      end
      it = random_item(ertt_pkg::OP_START, 29'd400);   // no room, nothing appended
      send_item(it);
      it = random_item(ertt_pkg::OP_QUERY, 29'd400);
      send_item(it);
      it = random_item(ertt_pkg::OP_START, 29'd100);   // own entry freed first, so it fits
      it.now = 32'd0;
      it.len = 16'd60000;
      send_item(it);
      it = random_item(ertt_pkg::OP_TICK, 29'd0);
      it.now = 32'd200;
      send_item(it);
      it = random_item(ertt_pkg::OP_TICK, 29'd0);
      it.now = 32'd70000;
      send_item(it);
      go_quiet();
   endtask

   task automatic test_pause_drain();
      tween_req_type it;
      for (int i = 0; i < 4; i++) begin
         it = random_item(ertt_pkg::OP_START, win_pool[i]);
         send_item(it);
      end
      it = random_item(ertt_pkg::OP_TICK, 29'd0);
      it.now = clock_ms + 32'd40;
      send_item(it);
      // hold off until the table has answered everything
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_moves.size() == 0);
      it = random_item(ertt_pkg::OP_TICK, 29'd0);
      it.now = clock_ms + 32'd80000;
      send_item(it);
      go_quiet();
   endtask

   task automatic test_random_traffic(int n_items);
      tween_req_type it;
      int         pick;
      logic [28:0] win;
      for (int n = 0; n < n_items; n++) begin
         if (n > n_items - 100)
            idle_enable = 1'b0;
         if ($urandom_range(0, 19) == 0)
            clock_ms = $urandom;
         else
            clock_ms = clock_ms + $urandom_range(0, 1500);
         win  = ($urandom_range(0, 9) == 0) ? 29'($urandom) : win_pool[$urandom_range(0, 11)];
         pick = $urandom_range(0, 99);
         if (pick < 35)
            it = random_item(ertt_pkg::OP_START, win);
         else if (pick < 40)
            it = random_item(ertt_pkg::OP_START, 29'd0);
         else if (pick < 50)
            it = random_item(ertt_pkg::OP_CANCEL, win);
         else if (pick < 65)
            it = random_item(ertt_pkg::OP_QUERY, win);
         else
            it = random_item(ertt_pkg::OP_TICK, 29'($urandom));
         send_item(it);
      end
      go_quiet();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      anim_count  = 0;
      clock_ms    = $urandom;
      idle_enable = 1'b1;
      for (int i = 0; i < 12; i++)
         win_pool[i] = (i < 6) ? 29'(i + 1) : 29'($urandom | 1);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_table_full();
      test_pause_drain();
      test_random_traffic(410);

      if (mismatches == 0 && pending_moves.size() == 0)
         $display("eased_rect_tween_table test passed");
      else
         $display("eased_rect_tween_table test failed");
      $finish;
   end

endmodule
